FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Condition must never be true out of reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion failed: forbidden condition");

`endif

FILE: rtl/core/gf25plj_pkg.sv
// GF(25) element type and field arithmetic for the line join pipeline.
package gf25plj_pkg;

  localparam int unsigned CodeW = 5;
  localparam int unsigned DigW  = 3;
  localparam int unsigned Base  = 5;
  localparam int unsigned Size  = 25;

  // re + i*im with i*i = 2, both digits canonical 0..4
  typedef struct packed {
    logic [DigW-1:0] re;
    logic [DigW-1:0] im;
  } gf_t;

  localparam gf_t GfZero = '{re: 3'd0, im: 3'd0};
  localparam gf_t GfOne  = '{re: 3'd1, im: 3'd0};

  // Reduce a 6-bit value mod 5: 16 is 1 mod 5, so fold the top bits in first.
  function automatic logic [DigW-1:0] mod5(input logic [5:0] x);
    logic [4:0] s;
    s = 5'(x[5:4]) + 5'(x[3:0]);
    if (s >= 5'd15) begin
      s = s - 5'd15;
    end else if (s >= 5'd10) begin
      s = s - 5'd10;
    end else if (s >= 5'd5) begin
      s = s - 5'd5;
    end
    return s[DigW-1:0];
  endfunction

  // Codes 25..31 alias 0..6.
  function automatic gf_t gf_dec(input logic [CodeW-1:0] x);
    logic [CodeW-1:0] y;
    logic [DigW-1:0]  im;
    logic [CodeW-1:0] re;
    gf_t              r;
    y  = (x >= CodeW'(Size)) ? x - CodeW'(Size) : x;
    if (y >= 5'd20) begin
      im = 3'd4;
    end else if (y >= 5'd15) begin
      im = 3'd3;
    end else if (y >= 5'd10) begin
      im = 3'd2;
    end else if (y >= 5'd5) begin
      im = 3'd1;
    end else begin
      im = 3'd0;
    end
    re   = y - ({2'b00, im} << 2) - {2'b00, im};
    r.re = re[DigW-1:0];
    r.im = im;
    return r;
  endfunction

  function automatic logic [CodeW-1:0] gf_enc(input gf_t x);
    return CodeW'(x.re) + (CodeW'(x.im) << 2) + CodeW'(x.im);
  endfunction

  function automatic gf_t gf_add(input gf_t x, input gf_t y);
    gf_t r;
    r.re = mod5(6'(x.re) + 6'(y.re));
    r.im = mod5(6'(x.im) + 6'(y.im));
    return r;
  endfunction

  function automatic gf_t gf_sub(input gf_t x, input gf_t y);
    gf_t r;
    r.re = mod5(6'(x.re) + 6'(Base) - 6'(y.re));
    r.im = mod5(6'(x.im) + 6'(Base) - 6'(y.im));
    return r;
  endfunction

  function automatic gf_t gf_mul(input gf_t x, input gf_t y);
    logic [5:0] pre;
    logic [5:0] pim;
    gf_t        r;
    pre  = 6'(x.re) * 6'(y.re) + ((6'(x.im) * 6'(y.im)) << 1);
    pim  = 6'(x.re) * 6'(y.im) + 6'(x.im) * 6'(y.re);
    r.re = mod5(pre);
    r.im = mod5(pim);
    return r;
  endfunction

  // Parallel search over the 24 nonzero candidates; zero maps to zero.
  function automatic gf_t gf_inv(input gf_t x);
    gf_t r;
    gf_t cand;
    r = GfZero;
    for (int k = 1; k < Size; k++) begin
      cand = gf_dec(CodeW'(k));
      if (gf_mul(x, cand) == GfOne) begin
        r = cand;
      end
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/gf25_projective_line_join.sv
// Projective line join over GF(25) with incidence test, four-stage pipeline.
//
//   channel | handshake                  | payload
//   --------+----------------------------+--------------------------------------------
//   in      | in_valid_i / in_stall_o    | a_*_i, b_*_i, t_*_i (GF(25) codes)
//   out     | out_valid_o / out_stall_i  | line_*_o, degenerate_o, test_on_line_o
//
// One beat can enter every cycle while in_stall_o is low.
// Stage 1 cross product, stage 2 pivot and inverse, stage 3 scale, stage 4 dot product.
// Reset clears only the stage valid bits; the pipeline is empty after reset.
// A stage holds while the one after it is full and held; bubbles are squeezed out,
// and in_stall_o rises only when all four stages are full and out_stall_i is high.
module gf25_projective_line_join (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [gf25plj_pkg::CodeW-1:0] a_first_i,
  input  logic [gf25plj_pkg::CodeW-1:0] a_second_i,
  input  logic [gf25plj_pkg::CodeW-1:0] a_third_i,
  input  logic [gf25plj_pkg::CodeW-1:0] b_first_i,
  input  logic [gf25plj_pkg::CodeW-1:0] b_second_i,
  input  logic [gf25plj_pkg::CodeW-1:0] b_third_i,
  input  logic [gf25plj_pkg::CodeW-1:0] t_first_i,
  input  logic [gf25plj_pkg::CodeW-1:0] t_second_i,
  input  logic [gf25plj_pkg::CodeW-1:0] t_third_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [gf25plj_pkg::CodeW-1:0] line_first_o,
  output logic [gf25plj_pkg::CodeW-1:0] line_second_o,
  output logic [gf25plj_pkg::CodeW-1:0] line_third_o,
  output logic                        degenerate_o,
  output logic                        test_on_line_o
);
  import gf25plj_pkg::*;

  localparam int unsigned NumStages = 4;

  logic [NumStages-1:0] vld_q;
  logic [NumStages:0]   rdy;

  gf_t v1_q [3];
  gf_t t1_q [3];
  gf_t v1_d [3];
  gf_t t1_d [3];

  gf_t v2_q [3];
  gf_t t2_q [3];
  gf_t scale2_q;
  logic deg2_q;
  gf_t scale2_d;
  logic deg2_d;

  gf_t ln3_q [3];
  gf_t t3_q [3];
  logic deg3_q;
  gf_t ln3_d [3];

  logic [CodeW-1:0] line4_q [3];
  logic             deg4_q;
  logic             on4_q;
  logic [CodeW-1:0] line4_d [3];
  logic             on4_d;

  gf_t a_in [3];
  gf_t b_in [3];
  gf_t dot;

  // Ready chain: a stage advances when empty or when its successor advances.
  always_comb begin
    rdy[NumStages] = !out_stall_i;
    for (int s = NumStages - 1; s >= 0; s--) begin
      rdy[s] = !vld_q[s] || rdy[s+1];
    end
  end

  assign in_stall_o = !rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int s = 1; s < NumStages; s++) begin
        if (rdy[s]) begin
          vld_q[s] <= vld_q[s-1];
        end
      end
    end
  end

  // Stage 1: decode and cross product.
  always_comb begin
    a_in[0] = gf_dec(a_first_i);
    a_in[1] = gf_dec(a_second_i);
    a_in[2] = gf_dec(a_third_i);
    b_in[0] = gf_dec(b_first_i);
    b_in[1] = gf_dec(b_second_i);
    b_in[2] = gf_dec(b_third_i);
    t1_d[0] = gf_dec(t_first_i);
    t1_d[1] = gf_dec(t_second_i);
    t1_d[2] = gf_dec(t_third_i);
    v1_d[0] = gf_sub(gf_mul(a_in[1], b_in[2]), gf_mul(a_in[2], b_in[1]));
    v1_d[1] = gf_sub(gf_mul(a_in[2], b_in[0]), gf_mul(a_in[0], b_in[2]));
    v1_d[2] = gf_sub(gf_mul(a_in[0], b_in[1]), gf_mul(a_in[1], b_in[0]));
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      v1_q <= v1_d;
      t1_q <= t1_d;
    end
  end

  // Stage 2: pick the pivot and invert it.
  always_comb begin
    deg2_d = (v1_q[0] == GfZero) && (v1_q[1] == GfZero) && (v1_q[2] == GfZero);
    priority if (v1_q[0] != GfZero) begin
      scale2_d = gf_inv(v1_q[0]);
    end else if (v1_q[1] != GfZero) begin
      scale2_d = gf_inv(v1_q[1]);
    end else begin
      scale2_d = gf_inv(v1_q[2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1] && vld_q[0]) begin
      v2_q     <= v1_q;
      t2_q     <= t1_q;
      scale2_q <= scale2_d;
      deg2_q   <= deg2_d;
    end
  end

  // Stage 3: normalize; a zero line scales to zero on its own.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ln3_d[k] = gf_mul(v2_q[k], scale2_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[2] && vld_q[1]) begin
      ln3_q  <= ln3_d;
      t3_q   <= t2_q;
      deg3_q <= deg2_q;
    end
  end

  // Stage 4: incidence test and re-encode.
  always_comb begin
    dot = gf_add(gf_add(gf_mul(t3_q[0], ln3_q[0]), gf_mul(t3_q[1], ln3_q[1])),
                 gf_mul(t3_q[2], ln3_q[2]));
    on4_d = !deg3_q && (dot == GfZero);
    for (int k = 0; k < 3; k++) begin
      line4_d[k] = gf_enc(ln3_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[3] && vld_q[2]) begin
      line4_q <= line4_d;
      deg4_q  <= deg3_q;
      on4_q   <= on4_d;
    end
  end

  assign out_valid_o    = vld_q[NumStages-1];
  assign line_first_o   = line4_q[0];
  assign line_second_o  = line4_q[1];
  assign line_third_o   = line4_q[2];
  assign degenerate_o   = deg4_q;
  assign test_on_line_o = on4_q;

`include "assert_macros.svh"

  `ASSERT_IMPLY(a_deg_zero, clk_i, rst_ni, out_valid_o && degenerate_o, line_first_o == '0 && line_second_o == '0 && line_third_o == '0 && !test_on_line_o)
  `ASSERT_IMPLY(a_norm_pivot, clk_i, rst_ni, out_valid_o && !degenerate_o, line_first_o == 5'd1 || (line_first_o == '0 && (line_second_o == 5'd1 || (line_second_o == '0 && line_third_o == 5'd1))))
  `ASSERT_IMPLY(a_stall_full, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i && vld_q[0] && vld_q[1] && vld_q[2])

endmodule

FILE: test/gf25_projective_line_join_tb.sv
// Self-checking testbench for the GF(25) projective line join with incidence test.
module gf25_projective_line_join_tb;

  localparam int unsigned CW         = gf25plj_pkg::CodeW;
  localparam int unsigned NONRESIDUE = 2;
  localparam int unsigned IDLE_PCT   = 28;
  localparam int unsigned LATENCY    = 4;
  localparam int unsigned CYCLE_CAP  = 200000;

  typedef logic [CW-1:0] code_t;
  typedef code_t [2:0] triple_t;

  typedef struct packed {
    triple_t a;
    triple_t b;
    triple_t t;
  } query_t;

  typedef struct packed {
    code_t line_first;
    code_t line_second;
    code_t line_third;
    logic  degenerate;
    logic  test_on_line;
  } join_t;

  typedef enum logic [1:0] {
    QK_FREE,
    QK_PROPORTIONAL,
    QK_ON_LINE,
    QK_SPARSE
  } query_kind_e;

  logic  clk_i          = 1'b0;
  logic  rst_ni         = 1'b0;
  logic  in_valid_i     = 1'b0;
  logic  in_stall_o;
  code_t a_first_i      = '0;
  code_t a_second_i     = '0;
  code_t a_third_i      = '0;
  code_t b_first_i      = '0;
  code_t b_second_i     = '0;
  code_t b_third_i      = '0;
  code_t t_first_i      = '0;
  code_t t_second_i     = '0;
  code_t t_third_i      = '0;
  logic  out_valid_o;
  logic  out_stall_i    = 1'b0;
  code_t line_first_o;
  code_t line_second_o;
  code_t line_third_o;
  logic  degenerate_o;
  logic  test_on_line_o;

  join_t       pending_lines[$];
  logic        steady_flow    = 1'b0;
  int unsigned mismatches     = 0;
  int unsigned joins_seen     = 0;
  int unsigned degenerate_seen = 0;
  int unsigned on_line_seen   = 0;
  int unsigned cycle_count    = 0;

  gf25_projective_line_join DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .a_first_i      (a_first_i),
    .a_second_i     (a_second_i),
    .a_third_i      (a_third_i),
    .b_first_i      (b_first_i),
    .b_second_i     (b_second_i),
    .b_third_i      (b_third_i),
    .t_first_i      (t_first_i),
    .t_second_i     (t_second_i),
    .t_third_i      (t_third_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .line_first_o   (line_first_o),
    .line_second_o  (line_second_o),
    .line_third_o   (line_third_o),
    .degenerate_o   (degenerate_o),
    .test_on_line_o (test_on_line_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // GF(25) arithmetic on raw 5-bit codes; codes above 24 fold by digit.
  function automatic int unsigned fe_re(code_t x);
    return int'(x) % gf25plj_pkg::Base;
  endfunction

  function automatic int unsigned fe_im(code_t x);
    return (int'(x) / gf25plj_pkg::Base) % gf25plj_pkg::Base;
  endfunction

  function automatic code_t fe_pack(int unsigned re, int unsigned im);
    return code_t'(re % gf25plj_pkg::Base + gf25plj_pkg::Base * (im % gf25plj_pkg::Base));
  endfunction

  function automatic code_t fe_add(code_t x, code_t y);
    return fe_pack(fe_re(x) + fe_re(y), fe_im(x) + fe_im(y));
  endfunction

  function automatic code_t fe_sub(code_t x, code_t y);
    return fe_pack(fe_re(x) + gf25plj_pkg::Base - fe_re(y),
                   fe_im(x) + gf25plj_pkg::Base - fe_im(y));
  endfunction

  function automatic code_t fe_mul(code_t x, code_t y);
    int unsigned xr, xi, yr, yi;
    xr = fe_re(x);
    xi = fe_im(x);
    yr = fe_re(y);
    yi = fe_im(y);
    return fe_pack(xr * yr + NONRESIDUE * xi * yi, xr * yi + xi * yr);
  endfunction

  function automatic code_t fe_inv(code_t x);
    for (int k = 1; k < gf25plj_pkg::Size; k++) begin
      if (fe_mul(x, code_t'(k)) == code_t'(1)) begin
        return code_t'(k);
      end
    end
    return '0;
  endfunction

  // j*p + k*q, coordinate by coordinate
  function automatic triple_t combine(code_t j, triple_t p, code_t k, triple_t q);
    triple_t r;
    for (int n = 0; n < 3; n++) begin
      r[n] = fe_add(fe_mul(j, p[n]), fe_mul(k, q[n]));
    end
    return r;
  endfunction

  function automatic join_t join_points(query_t q);
    triple_t v;
    code_t   scale;
    code_t   dot;
    join_t   r;
    v[0] = fe_sub(fe_mul(q.a[1], q.b[2]), fe_mul(q.a[2], q.b[1]));
    v[1] = fe_sub(fe_mul(q.a[2], q.b[0]), fe_mul(q.a[0], q.b[2]));
    v[2] = fe_sub(fe_mul(q.a[0], q.b[1]), fe_mul(q.a[1], q.b[0]));
    r = '0;
    if (v == '0) begin
      r.degenerate = 1'b1;
      return r;
    end
    scale = fe_inv((v[0] != '0) ? v[0] : ((v[1] != '0) ? v[1] : v[2]));
    for (int n = 0; n < 3; n++) begin
      v[n] = fe_mul(v[n], scale);
    end
    dot = fe_add(fe_add(fe_mul(q.t[0], v[0]), fe_mul(q.t[1], v[1])), fe_mul(q.t[2], v[2]));
    r.line_first   = v[0];
    r.line_second  = v[1];
    r.line_third   = v[2];
    r.test_on_line = (dot == '0);
    return r;
  endfunction

  function automatic query_t make_query(code_t a0, code_t a1, code_t a2,
                                        code_t b0, code_t b1, code_t b2,
                                        code_t t0, code_t t1, code_t t2);
    query_t q;
    q.a = '{a2, a1, a0};
    q.b = '{b2, b1, b0};
    q.t = '{t2, t1, t0};
    return q;
  endfunction

  // Mostly canonical codes, with the aliased codes 25..31 now and then.
  function automatic code_t rand_code();
    if ($urandom_range(0, 7) == 0) begin
      return code_t'($urandom_range(25, 31));
    end
    return code_t'($urandom_range(0, 24));
  endfunction

  function automatic triple_t rand_triple();
    return '{rand_code(), rand_code(), rand_code()};
  endfunction

  function automatic query_t rand_query();
    int unsigned pick;
    query_kind_e kind;
    query_t      q;
    pick = $urandom_range(0, 99);
    kind = (pick < 50) ? QK_FREE : (pick < 62) ? QK_PROPORTIONAL :
           (pick < 85) ? QK_ON_LINE : QK_SPARSE;
    q.a = rand_triple();
    q.b = rand_triple();
    q.t = rand_triple();
    case (kind)
      QK_PROPORTIONAL: begin
        q.b = combine(rand_code(), q.a, '0, q.a);
      end
      QK_ON_LINE: begin
        q.t = combine(rand_code(), q.a, rand_code(), q.b);
      end
      QK_SPARSE: begin
        for (int n = 0; n < 3; n++) begin
          if ($urandom_range(0, 1) == 0) q.a[n] = '0;
          if ($urandom_range(0, 1) == 0) q.b[n] = '0;
          if ($urandom_range(0, 1) == 0) q.t[n] = '0;
        end
      end
      default: begin
      end
    endcase
    return q;
  endfunction

  function automatic logic side_idles();
    return !steady_flow && ($urandom_range(0, 99) < IDLE_PCT);
  endfunction

  // Drive one beat at the falling edge and hold it until it is taken.
  task automatic send_query(input query_t q);
    @(negedge clk_i);
    while (side_idles()) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    a_first_i  <= q.a[0];
    a_second_i <= q.a[1];
    a_third_i  <= q.a[2];
    b_first_i  <= q.b[0];
    b_second_i <= q.b[1];
    b_third_i  <= q.b[2];
    t_first_i  <= q.t[0];
    t_second_i <= q.t[1];
    t_third_i  <= q.t[2];
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_lines.insert(pending_lines.size(), join_points(q));
  endtask

  task automatic drain_lines();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_lines.size() != 0) @(posedge clk_i);
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= side_idles();
  end

  always @(posedge clk_i) begin : line_check
    join_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_lines.size() == 0) begin
        $error("output beat with no line expected");
        mismatches++;
      end else begin
        want = pending_lines.pop_front();
        joins_seen++;
        if (want.degenerate) degenerate_seen++;
        if (want.test_on_line) on_line_seen++;
        if (line_first_o !== want.line_first) begin
          $error("line_first: expected %0d, got %0d", want.line_first, line_first_o);
          mismatches++;
        end
        if (line_second_o !== want.line_second) begin
          $error("line_second: expected %0d, got %0d", want.line_second, line_second_o);
          mismatches++;
        end
        if (line_third_o !== want.line_third) begin
          $error("line_third: expected %0d, got %0d", want.line_third, line_third_o);
          mismatches++;
        end
        if (degenerate_o !== want.degenerate) begin
          $error("degenerate: expected %0d, got %0d", want.degenerate, degenerate_o);
          mismatches++;
        end
        if (test_on_line_o !== want.test_on_line) begin
          $error("test_on_line: expected %0d, got %0d", want.test_on_line, test_on_line_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_CAP) begin
      $display("gf25_projective_line_join_tb: errors");
      $finish;
    end
  end

  task automatic test_corner_joins();
    // zero points and proportional points give no line
    send_query(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_query(make_query(24, 24, 24, 24, 24, 24, 24, 24, 24));
    send_query(make_query(31, 31, 31, 31, 31, 31, 31, 31, 31));
    send_query(make_query(0, 0, 0, 7, 13, 24, 1, 2, 3));
    send_query(make_query(9, 18, 4, 0, 0, 0, 0, 0, 0));
    send_query(make_query(7, 13, 24, fe_mul(3, 7), fe_mul(3, 13), fe_mul(3, 24), 1, 2, 3));
    send_query(make_query(6, 0, 22, fe_mul(17, 6), 0, fe_mul(17, 22), 0, 0, 0));
    // pivot in each coordinate
    send_query(make_query(1, 0, 0, 0, 1, 0, 0, 0, 0));
    send_query(make_query(1, 0, 0, 0, 0, 1, 0, 1, 0));
    send_query(make_query(0, 1, 0, 0, 0, 1, 1, 0, 0));
    send_query(make_query(0, 1, 0, 0, 0, 1, 0, 24, 24));
    // test point on the line: A, B, a mix of both, and the zero point
    send_query(make_query(3, 11, 20, 8, 2, 14, 3, 11, 20));
    send_query(make_query(3, 11, 20, 8, 2, 14, 8, 2, 14));
    send_query(make_query(3, 11, 20, 8, 2, 14, fe_add(3, 8), fe_add(11, 2), fe_add(20, 14)));
    send_query(make_query(3, 11, 20, 8, 2, 14, 0, 0, 0));
    // extreme and aliased codes
    send_query(make_query(24, 0, 24, 0, 24, 0, 24, 24, 24));
    send_query(make_query(25, 26, 27, 28, 29, 30, 31, 31, 31));
    send_query(make_query(31, 30, 29, 0, 31, 25, 30, 26, 28));
    send_query(make_query(0, 24, 1, 24, 0, 23, 31, 0, 25));
    send_query(make_query(5, 10, 15, 20, 1, 2, 4, 9, 19));
  endtask

  task automatic test_random_joins(input int unsigned count);
    for (int unsigned n = 0; n < count; n++) begin
      send_query(rand_query());
    end
  endtask

  task automatic test_back_to_back(input int unsigned count);
    steady_flow = 1'b1;
    test_random_joins(count);
    steady_flow = 1'b0;
  endtask

  task automatic test_pause_for_drain();
    drain_lines();
    test_random_joins(20);
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_corner_joins();
    test_random_joins(250);
    test_back_to_back(150);
    test_pause_for_drain();
    test_random_joins(180);
    drain_lines();
    repeat (2 * LATENCY) @(posedge clk_i);
    if (pending_lines.size() != 0) begin
      $error("%0d expected lines never came out", pending_lines.size());
      mismatches++;
    end
    $display("checked %0d joins: %0d without a unique line, %0d with the test point on it",
             joins_seen, degenerate_seen, on_line_seen);
    if (mismatches == 0) begin
      $display("gf25_projective_line_join_tb: clean");
    end else begin
      $display("gf25_projective_line_join_tb: errors");
    end
    $finish;
  end

endmodule
